### hw/rtl/tba_pkg.sv
// Shared constants, codes and types of the tree bitmap identifier allocator.
package tba_pkg;

  localparam int LEAVES_DEF = 256;

  localparam int MIN_ID_W   = 15;
  localparam int ID_CNT_W   = 9;
  localparam int ID_W       = 16;
  localparam int STATUS_W   = 2;
  localparam int USE_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  localparam logic [MIN_ID_W-1:0] MIN_ID_RST = 15'd3;
  localparam logic [ID_CNT_W-1:0] ID_CNT_RST = 9'd5;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_ID   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ID_COUNT = 1'b1;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] STS_BAD_ID  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_BUILD_RD,
    ST_BUILD_WR,
    ST_IDLE,
    ST_DESCEND,
    ST_CLIMB,
    ST_DONE
  } tba_state_t;

  // Write request to the child-pair store: one enable per child slot.
  typedef struct packed {
    logic en_lo;
    logic en_hi;
    logic data;
  } tba_wr_t;

endpackage

### hw/rtl/tree_bitmap_id_allocator.sv
// Allocate: one tree level per cycle down, one per cycle up.
// Release: leaf freed, then a climb; out-of-range or tree-full results skip the tree walk.
// One item at a time; the next is taken while the last result waits in the output register.
// Reset: clear pass over all LEAVES-1 entries, then a rebuild sweep; input stalls.
// An id_count write while idle or rebuilding starts the same rebuild anew.
// Top level: configuration registers, usable leaf count, store and sequencer.
module tree_bitmap_id_allocator #(
  parameter int LEAVES = tba_pkg::LEAVES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [tba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tba_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic [tba_pkg::ID_W-1:0]         release_id,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tba_pkg::ID_W-1:0]         granted_id,
  output logic [tba_pkg::STATUS_W-1:0]     status
);

  localparam int AW = $clog2(LEAVES);

  logic [tba_pkg::MIN_ID_W-1:0] min_id;
  logic [tba_pkg::ID_CNT_W-1:0] id_count;
  logic [tba_pkg::USE_W-1:0]    cnt_ext;
  logic [tba_pkg::USE_W-1:0]    leaves_ext;
  logic [tba_pkg::USE_W-1:0]    usable;
  logic                         rebuild_req;

  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              rd_lo;
  logic              rd_hi;
  tba_pkg::tba_wr_t  wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_id   <= tba_pkg::MIN_ID_RST;
      id_count <= tba_pkg::ID_CNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tba_pkg::REG_MIN_ID:   min_id   <= cfg_data[tba_pkg::MIN_ID_W-1:0];
        tba_pkg::REG_ID_COUNT: id_count <= cfg_data[tba_pkg::ID_CNT_W-1:0];
        default:               min_id   <= min_id;
      endcase
    end
  end

  assign rebuild_req = cfg_wr_en && (cfg_index == tba_pkg::REG_ID_COUNT);

  // Clamp the count to the leaf capacity.
  assign cnt_ext    = tba_pkg::USE_W'(id_count);
  assign leaves_ext = tba_pkg::USE_W'(LEAVES);
  assign usable     = (cnt_ext > leaves_ext) ? leaves_ext : cnt_ext;

  tba_tree_mem #(
    .LEAVES (LEAVES)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_lo   (rd_lo),
    .rd_hi   (rd_hi),
    .wr_addr (wr_addr),
    .wr      (wr)
  );

  tba_ctrl #(
    .LEAVES (LEAVES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .release_id  (release_id),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .granted_id  (granted_id),
    .status      (status),
    .min_id      (min_id),
    .usable      (usable),
    .rebuild_req (rebuild_req),
    .rd_addr     (rd_addr),
    .rd_lo       (rd_lo),
    .rd_hi       (rd_hi),
    .wr_addr     (wr_addr),
    .wr          (wr)
  );

endmodule

### hw/rtl/tba_tree_mem.sv
// Child-pair store: entry p holds the full bits of nodes 2p+1 (lo) and 2p+2 (hi).
module tba_tree_mem #(
  parameter int LEAVES = tba_pkg::LEAVES_DEF
) (
  input  logic                      clk,
  input  logic [$clog2(LEAVES)-1:0] rd_addr,
  output logic                      rd_lo,
  output logic                      rd_hi,
  input  logic [$clog2(LEAVES)-1:0] wr_addr,
  input  tba_pkg::tba_wr_t          wr
);

  localparam int DEPTH = LEAVES - 1;

  logic lo_mem [DEPTH];
  logic hi_mem [DEPTH];

  always_ff @(posedge clk) begin
    rd_lo <= lo_mem[rd_addr];
    if (wr.en_lo) begin
      lo_mem[wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_hi <= hi_mem[rd_addr];
    if (wr.en_hi) begin
      hi_mem[wr_addr] <= wr.data;
    end
  end

endmodule

### hw/rtl/tba_ctrl.sv
// Sequencer: clear and rebuild sweeps, allocate descent, upward update, result register.
module tba_ctrl #(
  parameter int LEAVES = tba_pkg::LEAVES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [tba_pkg::ID_W-1:0]       release_id,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tba_pkg::ID_W-1:0]       granted_id,
  output logic [tba_pkg::STATUS_W-1:0]   status,
  input  logic [tba_pkg::MIN_ID_W-1:0]   min_id,
  input  logic [tba_pkg::USE_W-1:0]      usable,
  input  logic                           rebuild_req,
  output logic [$clog2(LEAVES)-1:0]      rd_addr,
  input  logic                           rd_lo,
  input  logic                           rd_hi,
  output logic [$clog2(LEAVES)-1:0]      wr_addr,
  output tba_pkg::tba_wr_t               wr
);

  localparam int AW = $clog2(LEAVES);
  localparam int SW = AW + 1;
  localparam logic [AW-1:0] LEAF_PAR = AW'(LEAVES / 2 - 1);
  localparam logic [AW-1:0] LAST     = AW'(LEAVES - 2);

  tba_pkg::tba_state_t state, state_next;

  logic [AW-1:0] node;
  logic [SW-1:0] sib;
  logic          val;
  logic          root_full;
  logic [tba_pkg::ID_W-1:0]     res_id;
  logic [tba_pkg::STATUS_W-1:0] res_status;

  logic          acc;
  logic          out_free;
  logic          is_leafp;
  logic [AW-1:0] base;
  logic [AW-1:0] off_lo;
  logic [AW-1:0] off_hi;
  logic          nf_lo;
  logic          nf_hi;
  logic          choose_hi;
  logic          sib_s;
  logic [AW-1:0] child;
  logic [AW-1:0] leaf_off;
  logic [AW-1:0] parent;
  logic          slot_hi;
  logic [tba_pkg::USE_W-1:0] rel_off;
  logic          rel_bad;
  logic [AW-1:0] rel_leaf;
  logic [AW-1:0] rel_entry;

  assign in_stall = (state != tba_pkg::ST_IDLE) || rebuild_req;
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Children of the current entry; leaves past the usable count read full.
  assign is_leafp = node >= LEAF_PAR;
  assign base     = node - LEAF_PAR;
  assign off_lo   = AW'({base, 1'b0});
  assign off_hi   = off_lo | AW'(1);
  assign nf_lo    = rd_lo || (is_leafp && (tba_pkg::USE_W'(off_lo) >= usable));
  assign nf_hi    = rd_hi || (is_leafp && (tba_pkg::USE_W'(off_hi) >= usable));
  assign choose_hi = nf_lo;
  assign sib_s     = choose_hi ? nf_lo : nf_hi;
  assign child     = AW'({node, 1'b0} + (AW+1)'(1) + (AW+1)'(choose_hi));
  assign leaf_off  = choose_hi ? off_hi : off_lo;
  assign parent    = AW'((node - AW'(1)) >> 1);
  assign slot_hi   = !node[0];

  assign rel_off   = {1'b0, release_id} - tba_pkg::USE_W'(min_id);
  assign rel_bad   = rel_off[tba_pkg::USE_W-1] ||
                     (tba_pkg::USE_W'(rel_off[tba_pkg::ID_W-1:0]) >= usable);
  assign rel_leaf  = rel_off[AW-1:0];
  assign rel_entry = LEAF_PAR + (rel_leaf >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tba_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tba_pkg::ST_CLEAR: begin
        if (node == LAST) state_next = tba_pkg::ST_BUILD_RD;
      end
      tba_pkg::ST_BUILD_RD: begin
        state_next = rebuild_req ? tba_pkg::ST_BUILD_RD : tba_pkg::ST_BUILD_WR;
      end
      tba_pkg::ST_BUILD_WR: begin
        if (rebuild_req) begin
          state_next = tba_pkg::ST_BUILD_RD;
        end else begin
          state_next = (node == '0) ? tba_pkg::ST_IDLE : tba_pkg::ST_BUILD_RD;
        end
      end
      tba_pkg::ST_IDLE: begin
        if (rebuild_req) begin
          state_next = tba_pkg::ST_BUILD_RD;
        end else if (acc) begin
          if (func == tba_pkg::FUNC_ALLOC) begin
            state_next = root_full ? tba_pkg::ST_DONE : tba_pkg::ST_DESCEND;
          end else begin
            state_next = rel_bad ? tba_pkg::ST_DONE : tba_pkg::ST_CLIMB;
          end
        end
      end
      tba_pkg::ST_DESCEND: begin
        if (is_leafp) state_next = tba_pkg::ST_CLIMB;
      end
      tba_pkg::ST_CLIMB: begin
        if (node == '0) state_next = tba_pkg::ST_DONE;
      end
      tba_pkg::ST_DONE: begin
        if (out_free) state_next = tba_pkg::ST_IDLE;
      end
      default: state_next = tba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr  = node;
    wr_addr  = node;
    wr.en_lo = 1'b0;
    wr.en_hi = 1'b0;
    wr.data  = 1'b0;
    case (state)
      tba_pkg::ST_CLEAR: begin
        wr.en_lo = 1'b1;
        wr.en_hi = 1'b1;
      end
      tba_pkg::ST_BUILD_RD: begin
        rd_addr = node;
      end
      tba_pkg::ST_BUILD_WR: begin
        if (node != '0) begin
          wr_addr  = parent;
          wr.en_lo = !slot_hi;
          wr.en_hi = slot_hi;
          wr.data  = nf_lo && nf_hi;
        end
      end
      tba_pkg::ST_IDLE: begin
        rd_addr = '0;
        // Release: free the leaf right away, ancestors follow in the climb.
        if (acc && func == tba_pkg::FUNC_RELEASE && !rel_bad) begin
          wr_addr  = rel_entry;
          wr.en_lo = !rel_leaf[0];
          wr.en_hi = rel_leaf[0];
        end
      end
      tba_pkg::ST_DESCEND: begin
        rd_addr = child;
        if (is_leafp) begin
          wr_addr  = node;
          wr.en_lo = !choose_hi;
          wr.en_hi = choose_hi;
          wr.data  = 1'b1;
        end
      end
      tba_pkg::ST_CLIMB: begin
        if (node != '0) begin
          wr_addr  = parent;
          wr.en_lo = !slot_hi;
          wr.en_hi = slot_hi;
          wr.data  = val;
        end
      end
      tba_pkg::ST_DONE: begin
        rd_addr = node;
      end
      default: begin
        rd_addr = node;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node      <= '0;
      root_full <= 1'b0;
    end else begin
      case (state)
        tba_pkg::ST_CLEAR: begin
          if (node != LAST) node <= node + AW'(1);
        end
        // A count write during the sweep restarts it from the last entry.
        tba_pkg::ST_BUILD_RD: begin
          if (rebuild_req) node <= LAST;
        end
        tba_pkg::ST_BUILD_WR: begin
          if (rebuild_req) begin
            node <= LAST;
          end else if (node == '0) begin
            root_full <= nf_lo && nf_hi;
          end else begin
            node <= node - AW'(1);
          end
        end
        tba_pkg::ST_IDLE: begin
          if (rebuild_req) begin
            node <= LAST;
          end else if (acc) begin
            if (func == tba_pkg::FUNC_ALLOC) begin
              node <= '0;
            end else if (!rel_bad) begin
              node <= rel_entry;
            end
          end
        end
        tba_pkg::ST_DESCEND: begin
          if (!is_leafp) node <= child;
        end
        tba_pkg::ST_CLIMB: begin
          if (node == '0) begin
            root_full <= val;
          end else begin
            node <= parent;
          end
        end
        tba_pkg::ST_DONE: begin
          node <= node;
        end
        default: begin
          node <= node;
        end
      endcase
    end
  end

  // Sibling fullness along the path; the climb folds it back toward the root.
  always_ff @(posedge clk) begin
    case (state)
      tba_pkg::ST_IDLE: begin
        if (acc) begin
          sib        <= '0;
          val        <= 1'b0;
          res_id     <= '0;
          if (func == tba_pkg::FUNC_ALLOC) begin
            res_status <= root_full ? tba_pkg::STS_NO_FREE : tba_pkg::STS_OK;
          end else begin
            res_status <= rel_bad ? tba_pkg::STS_BAD_ID : tba_pkg::STS_OK;
          end
        end
      end
      tba_pkg::ST_DESCEND: begin
        sib <= {sib[SW-2:0], sib_s};
        if (is_leafp) begin
          val    <= sib_s;
          res_id <= tba_pkg::ID_W'(min_id) + tba_pkg::ID_W'(leaf_off);
        end
      end
      tba_pkg::ST_CLIMB: begin
        val <= val && sib[1];
        sib <= sib >> 1;
      end
      default: begin
        val <= val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tba_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tba_pkg::ST_DONE && out_free) begin
      granted_id <= res_id;
      status     <= res_status;
    end
  end

endmodule
